[rtl/gb3_pkg.sv]
// Shared types, constants and the kernel arithmetic for the 3x3 Gaussian blur.
package gb3_pkg;

    // Gray value width, fixed by the item fields.
    localparam int PIXEL_BITS = 8;

    // Default storage limits handed to the top level.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration port.
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_INDEX_W       = 1;
    localparam int FRAME_WIDTH_BITS  = 11;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int RESET_FRAME_WIDTH  = 1024;
    localparam int RESET_FRAME_HEIGHT = 768;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Item modes.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Kernel 1-2-1 / 2-4-2 / 1-2-1, normalized by a right shift.
    localparam int KERNEL_TAPS  = 9;
    localparam int KERNEL_SHIFT = 4;
    localparam int KERNEL [KERNEL_TAPS] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
    localparam int SUM_W = PIXEL_BITS + KERNEL_SHIFT;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [KERNEL_TAPS-1:0] window_t;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  frame_end;
    } out_item_t;

    // What the front decided about one queued item.
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } op_flags_t;

    // Weighted sum over the nine window taps.
    function automatic logic [SUM_W-1:0] blur_sum(input window_t win);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < KERNEL_TAPS; i++)
        begin
            acc = acc + SUM_W'(win[i]) * SUM_W'(KERNEL[i]);
        end
        return acc;
    endfunction

endpackage

[rtl/gb3_fifo.sv]
// Small first-in first-out queue between the front and the back.
module gb3_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = gb3_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/gb3_front.sv]
// Front part: frame registers, position counters and classification of each item.
module gb3_front #(
    parameter int MAX_WIDTH  = gb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  gb3_pkg::in_item_t                    in_item,
    output logic                                 in_stall,
    input  logic                                 cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 q_full,
    output logic                                 push,
    output gb3_pkg::pix_t                        push_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]         push_col,
    output gb3_pkg::op_flags_t                   push_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RESET_W_EFF = (gb3_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                                 MAX_WIDTH : gb3_pkg::RESET_FRAME_WIDTH;
    localparam int RESET_H_EFF = (gb3_pkg::RESET_FRAME_HEIGHT > MAX_HEIGHT) ?
                                 MAX_HEIGHT : gb3_pkg::RESET_FRAME_HEIGHT;

    logic [WID_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic             accept;
    logic             input_done;
    logic             emit;
    logic             interior;
    logic             last;
    logic [WID_W:0]   in_col_plus;
    logic [WID_W:0]   out_col_plus;
    logic [ROW_W:0]   out_row_ext;
    logic [ROW_W:0]   height_ext;
    logic [WID_W:0]   width_ext;
    logic [31:0]      width_val;
    logic [31:0]      height_val;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classification of the item at the input.
    assign input_done   = (in_row_reg >= ROW_W'(height_reg));
    assign push         = accept && !((in_item.mode == gb3_pkg::MODE_FLUSH) && !input_done);
    assign emit         = (in_row_reg >= ROW_W'(2)) ||
                          ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign in_col_plus  = (WID_W + 1)'(in_col_reg) + (WID_W + 1)'(1);
    assign out_col_plus = (WID_W + 1)'(out_col_reg) + (WID_W + 1)'(1);
    assign out_row_ext  = (ROW_W + 1)'(out_row_reg);
    assign height_ext   = (ROW_W + 1)'(height_reg);
    assign width_ext    = (WID_W + 1)'(width_reg);

    // Interior pixels have a full neighborhood inside the frame.
    assign interior = (out_row_reg != '0) && (out_row_ext + (ROW_W + 1)'(2) <= height_ext) &&
                      (out_col_reg != '0) && (out_col_plus + (WID_W + 1)'(1) <= width_ext);
    assign last     = (out_row_ext + (ROW_W + 1)'(1) == height_ext) &&
                      (out_col_plus == width_ext);

    // A pixel that arrives after the frame acts as a flush with value zero.
    assign push_pix   = input_done ? '0 : in_item.pixel_in;
    assign push_col   = in_col_reg;
    assign push_flags = '{emit: emit, interior: interior, last: last};

    assign width_val  = 32'(cfg_data[gb3_pkg::FRAME_WIDTH_BITS-1:0]);
    assign height_val = 32'(cfg_data[gb3_pkg::FRAME_HEIGHT_BITS-1:0]);

    // Register writes and counter advance.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                gb3_pkg::REG_FRAME_WIDTH:
                begin
                    if (width_val == 32'd0)
                    begin
                        width_next = WID_W'(1);
                    end
                    else if (width_val > 32'(MAX_WIDTH))
                    begin
                        width_next = WID_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WID_W'(width_val);
                    end
                end
                gb3_pkg::REG_FRAME_HEIGHT:
                begin
                    if (height_val == 32'd0)
                    begin
                        height_next = HGT_W'(1);
                    end
                    else if (height_val > 32'(MAX_HEIGHT))
                    begin
                        height_next = HGT_W'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = HGT_W'(height_val);
                    end
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (push)
        begin
            if (in_col_plus >= width_ext)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = COL_W'(in_col_plus);
            end
            if (emit)
            begin
                if (out_col_plus >= width_ext)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = COL_W'(out_col_plus);
                end
                // The frame's last output restarts the frame.
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WID_W'(RESET_W_EFF);
            height_reg  <= HGT_W'(RESET_H_EFF);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

[rtl/gb3_back.sv]
// Back part: line stores, 3x3 window, kernel sum and the output register.
module gb3_back #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic                          q_valid,
    input  gb3_pkg::pix_t                 q_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    input  gb3_pkg::op_flags_t            q_flags,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gb3_pkg::out_item_t            out_item
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Line stores, one entry per column.
    gb3_pkg::pix_t upper_mem  [MAX_WIDTH];
    gb3_pkg::pix_t middle_mem [MAX_WIDTH];

    logic                        s1_valid_reg, s1_valid_next;
    gb3_pkg::pix_t               s1_pix_reg;
    logic [COL_W-1:0]            s1_col_reg;
    gb3_pkg::op_flags_t          s1_flags_reg;
    gb3_pkg::pix_t               rd_up_reg;
    gb3_pkg::pix_t               rd_mid_reg;
    gb3_pkg::window_t            window_reg, window_next;
    gb3_pkg::window_t            window_shifted;
    logic                        out_valid_reg, out_valid_next;
    gb3_pkg::out_item_t          out_item_reg, out_item_next;
    logic [gb3_pkg::SUM_W-1:0]   sum;
    logic                        out_free;
    logic                        s1_advance;
    logic                        load_out;
    logic                        bypass;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Stage handshake: an item that produces a result needs a free output register.
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_flags_reg.emit || out_free);
    assign q_pop      = q_valid && (!s1_valid_reg || s1_advance);
    assign load_out   = s1_advance && s1_flags_reg.emit;

    // A read of the column being written in the same cycle takes the new data.
    assign bypass = s1_advance && (s1_col_reg == q_col);

    // Window shifts left by one column; the new column enters on the right.
    always_comb
    begin
        window_shifted    = window_reg;
        window_shifted[0] = window_reg[1];
        window_shifted[1] = window_reg[2];
        window_shifted[2] = rd_up_reg;
        window_shifted[3] = window_reg[4];
        window_shifted[4] = window_reg[5];
        window_shifted[5] = rd_mid_reg;
        window_shifted[6] = window_reg[7];
        window_shifted[7] = window_reg[8];
        window_shifted[8] = s1_pix_reg;
    end

    assign sum = gb3_pkg::blur_sum(window_shifted);

    // Next window, stage valid and result.
    always_comb
    begin
        window_next    = window_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (restart)
        begin
            window_next = '0;
        end
        else if (s1_advance)
        begin
            window_next = (s1_flags_reg.emit && s1_flags_reg.last) ? '0 : window_shifted;
        end
        if (q_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_item_next.pixel_out = s1_flags_reg.interior ?
                sum[gb3_pkg::SUM_W-1:gb3_pkg::KERNEL_SHIFT] : window_shifted[4];
            out_item_next.frame_end = s1_flags_reg.last;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
        end
    end

    // Line store write-back, registered reads and stage payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            upper_mem[s1_col_reg]  <= rd_mid_reg;
            middle_mem[s1_col_reg] <= s1_pix_reg;
        end
        if (q_pop)
        begin
            rd_up_reg    <= bypass ? rd_mid_reg : upper_mem[q_col];
            rd_mid_reg   <= bypass ? s1_pix_reg : middle_mem[q_col];
            s1_pix_reg   <= q_pix;
            s1_col_reg   <= q_col;
            s1_flags_reg <= q_flags;
        end
        out_item_reg <= out_item_next;
    end

endmodule

[rtl/gaussian_blur_3x3.sv]
// Top level of the streaming 3x3 Gaussian blur.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------
//  input    | in_valid / in_stall    | in_item  (mode, pixel_in)
//  output   | out_valid / out_stall  | out_item (pixel_out, frame_end)
//  config   | cfg_we                 | cfg_index, cfg_data
//
// One item per clock is sustained while out_stall is low; the back then takes one
// queued item each cycle through a single line store port pair with a registered read.
// Output k comes from input item k+W+1, which passes through the queue and the
// back stage registers before its result is loaded into the output register.
// Reset clears the counters, window and queue; the line stores are not cleared
// and need no clearing pass, since unwritten entries never reach a result.
// in_stall rises only when the four-item queue is full; out_stall holds the
// output register and backs up the back stage, then the queue.
module gaussian_blur_3x3 #(
    parameter int MAX_WIDTH  = gb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  gb3_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output gb3_pkg::out_item_t               out_item,
    input  logic                             cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int Q_W   = COL_W + $bits(gb3_pkg::op_flags_t) + gb3_pkg::PIXEL_BITS;

    logic               push;
    gb3_pkg::pix_t      push_pix;
    logic [COL_W-1:0]   push_col;
    gb3_pkg::op_flags_t push_flags;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [Q_W-1:0]     q_push_data;
    logic [Q_W-1:0]     q_pop_data;
    gb3_pkg::pix_t      q_pix;
    logic [COL_W-1:0]   q_col;
    gb3_pkg::op_flags_t q_flags;

    // Front: register writes, counters and classification.
    gb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .in_stall   (in_stall),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_pix   (push_pix),
        .push_col   (push_col),
        .push_flags (push_flags)
    );

    // Queue between front and back.
    assign q_push_data = {push_col, push_flags, push_pix};
    assign {q_col, q_flags, q_pix} = q_pop_data;

    gb3_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (gb3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_valid)
    );

    // Back: line stores, window and filter.
    gb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_we),
        .q_valid   (q_valid),
        .q_pix     (q_pix),
        .q_col     (q_col),
        .q_flags   (q_flags),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

[test/tb_top.sv]
// Testbench for the streaming 3x3 Gaussian blur: random frames checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 40;

    // Pixel patterns for frame content.
    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_EXTREME = 1;
    localparam int STYLE_NEAR    = 2;
    localparam int STYLE_FULL    = 3;

    // Predicts the filtered stream and holds the pixels still owed by the block.
    class blur_tracker;
        logic [gb3_pkg::FRAME_WIDTH_BITS-1:0]  width_reg;
        logic [gb3_pkg::FRAME_HEIGHT_BITS-1:0] height_reg;
        gb3_pkg::pix_t      upper_line [gb3_pkg::MAX_WIDTH_DEF];
        gb3_pkg::pix_t      middle_line [gb3_pkg::MAX_WIDTH_DEF];
        gb3_pkg::pix_t      win [9];
        int unsigned        in_row, in_col, out_row, out_col;
        gb3_pkg::out_item_t pending_pixels [$];
        int                 errors;

        function new();
            width_reg  = gb3_pkg::FRAME_WIDTH_BITS'(gb3_pkg::RESET_FRAME_WIDTH);
            height_reg = gb3_pkg::FRAME_HEIGHT_BITS'(gb3_pkg::RESET_FRAME_HEIGHT);
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
            foreach (win[i])
            begin
                win[i] = '0;
            end
        endfunction

        // Register values outside the legal range are clamped.
        function int unsigned width_eff();
            if (width_reg == 0)
            begin
                return 1;
            end
            return (width_reg > gb3_pkg::MAX_WIDTH_DEF) ? gb3_pkg::MAX_WIDTH_DEF
                                                        : int'(width_reg);
        endfunction

        function int unsigned height_eff();
            if (height_reg == 0)
            begin
                return 1;
            end
            return (height_reg > gb3_pkg::MAX_HEIGHT_DEF) ? gb3_pkg::MAX_HEIGHT_DEF
                                                          : int'(height_reg);
        endfunction

        // Any register write restarts the frame; line stores are kept.
        function void write_reg(logic [gb3_pkg::CFG_INDEX_W-1:0] index,
                                logic [gb3_pkg::CFG_DATA_W-1:0] data);
            if (index == gb3_pkg::REG_FRAME_WIDTH)
            begin
                width_reg = data[gb3_pkg::FRAME_WIDTH_BITS-1:0];
            end
            else
            begin
                height_reg = data[gb3_pkg::FRAME_HEIGHT_BITS-1:0];
            end
            restart_frame();
        endfunction

        // Returns 0 when the block ignores the item (a flush mid-frame).
        function bit take_item(gb3_pkg::in_item_t item);
            int unsigned        w, h, col, sum;
            gb3_pkg::pix_t      up, mid, pix, val;
            bit                 emit, last;
            gb3_pkg::out_item_t res;
            w = width_eff();
            h = height_eff();
            if (item.mode == gb3_pkg::MODE_FLUSH && in_row < h)
            begin
                return 0;
            end
            // Once the frame is in, every item drains and carries a zero pixel.
            pix = (in_row >= h) ? gb3_pkg::pix_t'(0) : item.pixel_in;
            col = (in_col < gb3_pkg::MAX_WIDTH_DEF) ? in_col : 0;
            up  = upper_line[col];
            mid = middle_line[col];
            upper_line[col]  = mid;
            middle_line[col] = pix;
            for (int r = 0; r < 3; r++)
            begin
                win[3*r]   = win[3*r+1];
                win[3*r+1] = win[3*r+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = pix;

            // Output starts once W + 2 items are in.
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (!emit)
            begin
                return 1;
            end

            if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w)
            begin
                sum = int'(win[0]) + int'(win[2]) + int'(win[6]) + int'(win[8])
                    + 2 * (int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]))
                    + 4 * int'(win[4]);
                val = gb3_pkg::pix_t'(sum >> gb3_pkg::KERNEL_SHIFT);
            end
            else
            begin
                val = win[4];
            end
            last = (out_row + 1 == h) && (out_col + 1 == w);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
            if (last)
            begin
                restart_frame();
            end
            res.pixel_out = val;
            res.frame_end = last;
            pending_pixels.push_back(res);
            return 1;
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_result(gb3_pkg::out_item_t got);
            gb3_pkg::out_item_t want;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $error("unexpected output item: pixel_out %0d, frame_end %0d",
                           got.pixel_out, got.frame_end);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out)
            begin
                report("pixel_out", want.pixel_out, got.pixel_out);
            end
            if (got.frame_end !== want.frame_end)
            begin
                report("frame_end", want.frame_end, got.frame_end);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    gb3_pkg::in_item_t               in_item;
    logic                            out_valid;
    logic                            out_stall;
    gb3_pkg::out_item_t              out_item;
    logic                            cfg_we;
    logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data;

    blur_tracker tracker;
    int          items_sent;
    int          gap_odds;
    int          stall_odds;
    int          cycle_count = 0;
    bit          hold_request;
    bit          hold_done;

    gaussian_blur_3x3 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Compare every accepted output item.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_result(out_item);
        end
    end

    // Receiver back-pressure: short random bursts and one long hold-off.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic gb3_pkg::pix_t pick_pixel(input int style);
        case (style)
            STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            STYLE_NEAR:    return $urandom_range(0, 1) ?
                                  gb3_pkg::pix_t'($urandom_range(248, 255)) :
                                  gb3_pkg::pix_t'($urandom_range(0, 7));
            STYLE_FULL:    return 8'hFF;
            default:       return gb3_pkg::pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Small widths, sometimes zero, sometimes with bits above the register set.
    function automatic logic [gb3_pkg::CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return gb3_pkg::CFG_DATA_W'(($urandom_range(1, 3)
                                                  << gb3_pkg::FRAME_WIDTH_BITS)
                                                 | $urandom_range(1, 12));
            default: return gb3_pkg::CFG_DATA_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [gb3_pkg::CFG_DATA_W-1:0] pick_height();
        if ($urandom_range(0, 9) == 0)
        begin
            return '0;
        end
        return gb3_pkg::CFG_DATA_W'($urandom_range(1, 10));
    endfunction

    // Offer one item, with an optional gap first, and wait until it is taken.
    task automatic send_item(input logic mode, input gb3_pkg::pix_t value);
        gb3_pkg::in_item_t item;
        item.mode     = mode;
        item.pixel_in = value;
        @(negedge clk);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (tracker.take_item(item))
        begin
            items_sent++;
        end
    endtask

    // Stop offering and let every owed pixel come out, then let the block settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gb3_pkg::CFG_INDEX_W-1:0] index,
                             input logic [gb3_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(index, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One whole frame at the current size, then the drain items.
    task automatic run_frame(input int style, input bit noise);
        int unsigned w, h;
        w = tracker.width_eff();
        h = tracker.height_eff();
        for (int unsigned i = 0; i < w * h; i++)
        begin
            if (noise && $urandom_range(0, 15) == 0)
            begin
                send_item(gb3_pkg::MODE_FLUSH, gb3_pkg::pix_t'($urandom_range(0, 255)));
            end
            send_item(gb3_pkg::MODE_PIXEL, pick_pixel(style));
        end
        // Drain with a mix of flush items and pixels that act as flushes.
        for (int unsigned i = 0; i <= w; i++)
        begin
            send_item($urandom_range(0, 1) ? gb3_pkg::MODE_FLUSH : gb3_pkg::MODE_PIXEL,
                      gb3_pkg::pix_t'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int kind;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        gap_odds     = 4;
        stall_odds   = 4;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        items_sent   = 0;
        tracker      = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset size: just past one full row so the first pixels come out.
        for (int i = 0; i < gb3_pkg::RESET_FRAME_WIDTH + 3; i++)
        begin
            send_item(gb3_pkg::MODE_PIXEL, pick_pixel(STYLE_RANDOM));
        end
        wait_idle();

        // Zero width and height act as a single pixel; flush mid-frame is ignored.
        write_reg(gb3_pkg::REG_FRAME_WIDTH, '0);
        write_reg(gb3_pkg::REG_FRAME_HEIGHT, '0);
        send_item(gb3_pkg::MODE_FLUSH, 8'hA5);
        send_item(gb3_pkg::MODE_PIXEL, 8'hFF);
        send_item(gb3_pkg::MODE_PIXEL, 8'h00);
        send_item(gb3_pkg::MODE_FLUSH, 8'h5A);
        send_item(gb3_pkg::MODE_FLUSH, 8'h3C);

        // Smallest frame with an interior, back to back without a register write.
        wait_idle();
        write_reg(gb3_pkg::REG_FRAME_WIDTH, gb3_pkg::CFG_DATA_W'(3));
        write_reg(gb3_pkg::REG_FRAME_HEIGHT, gb3_pkg::CFG_DATA_W'(3));
        run_frame(STYLE_FULL, 1'b0);
        run_frame(STYLE_EXTREME, 1'b0);

        // Narrow frame: everything passes through.
        wait_idle();
        write_reg(gb3_pkg::REG_FRAME_WIDTH, gb3_pkg::CFG_DATA_W'(2));
        write_reg(gb3_pkg::REG_FRAME_HEIGHT, gb3_pkg::CFG_DATA_W'(2));
        run_frame(STYLE_RANDOM, 1'b1);

        wait_idle();
        write_reg(gb3_pkg::REG_FRAME_WIDTH, pick_width());
        write_reg(gb3_pkg::REG_FRAME_HEIGHT, pick_height());

        // Random frames, resizes and abandoned frames.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = $urandom_range(0, 2) * 3;
                stall_odds = $urandom_range(0, 2) * 3;
            end
            kind = $urandom_range(0, 9);
            // Long hold-off over a frame with enough results to fill the block.
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                wait_idle();
                write_reg(gb3_pkg::REG_FRAME_WIDTH, gb3_pkg::CFG_DATA_W'(8));
                write_reg(gb3_pkg::REG_FRAME_HEIGHT, gb3_pkg::CFG_DATA_W'(6));
                hold_request = 1'b1;
                hold_done    = 1'b1;
                gap_odds     = 0;
                kind         = 9;
            end
            if (kind <= 2)
            begin
                wait_idle();
                write_reg(gb3_pkg::REG_FRAME_WIDTH, pick_width());
                write_reg(gb3_pkg::REG_FRAME_HEIGHT, pick_height());
            end
            else if (kind == 3)
            begin
                // Cut a frame short; the register write restarts it.
                repeat ($urandom_range(1, tracker.width_eff() * tracker.height_eff()))
                begin
                    send_item(gb3_pkg::MODE_PIXEL, pick_pixel(STYLE_RANDOM));
                end
                wait_idle();
                write_reg(gb3_pkg::REG_FRAME_WIDTH, pick_width());
            end
            run_frame($urandom_range(STYLE_RANDOM, STYLE_NEAR), 1'($urandom_range(0, 1)));
        end

        gap_odds   = 0;
        stall_odds = 0;
        wait_idle();
        if (tracker.errors == 0 && tracker.pending_pixels.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/gb3_pkg.sv
rtl/gb3_fifo.sv
rtl/gb3_front.sv
rtl/gb3_back.sv
rtl/gaussian_blur_3x3.sv
test/tb_top.sv
